[hdl/sst_pkg.sv]
// Shared types and constants for the sensor statistics table.
`default_nettype none
package sst_pkg;

   localparam int KEY_W      = 48;
   localparam int READING_W  = 16;
   localparam int COUNT_OUT_W = 9;

   localparam logic signed [READING_W-1:0] ALERT_THRESHOLD_RESET = 16'sd560;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MISS,
      ST_STAT,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

[hdl/sst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[hdl/sensor_stats_table_core.sv]
// Top level of the sensor statistics table: lookup, update and mean divide.
//
// One req beat carries a 48-bit sensor key and a signed Q11.4 reading; one rsp
// beat comes back for it with the alert bit, mean, minimum, maximum and count
// of that sensor. A new key takes the next free entry; when all SENSORS
// entries are in use the rsp beat has table_full set and every other field
// zero, and nothing is stored. Once a sensor holds READING_CAP readings its
// statistics freeze, but alert still follows the current reading. Items are
// handled one at a time. An item passes through the key search (one key memory
// read per entry in use, up to SENSORS entries), a read of the statistics
// entry, an update that writes it back, and the bit-serial restoring divide
// that forms the mean. The key search and the divider set the rate. A finished
// beat sits in the output register, so a new req beat is taken while the
// previous rsp beat is still waiting. Keys and statistics live in two
// memories; their contents need no clearing after reset, since only entries
// below the use count are ever used. alert_threshold is written through the
// csr port, which is always ready, and resets to 35.0 degrees.
`default_nettype none
module sensor_stats_table_core
   import sst_pkg::*;
#(
   parameter int SENSORS     = 32,
   parameter int READING_CAP = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic signed [READING_W-1:0] csr_alert_threshold,
   // request
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [KEY_W-1:0]            req_sensor_key,
   input  wire logic signed [READING_W-1:0] req_reading,
   // response
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_alert,
   output logic signed [READING_W-1:0]      rsp_mean,
   output logic signed [READING_W-1:0]      rsp_minimum,
   output logic signed [READING_W-1:0]      rsp_maximum,
   output logic [COUNT_OUT_W-1:0]           rsp_reading_count,
   output logic                             rsp_table_full
);

   localparam int IDX_W  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int USED_W = $clog2(SENSORS + 1);
   localparam int CNT_W  = $clog2(READING_CAP + 1);
   localparam int SUM_W  = READING_W + CNT_W;
   localparam int STAT_W = SUM_W + 2 * READING_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int CNT_EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

   // control
   state_type              state_ff, state_in;
   logic [USED_W-1:0]      entries_ff, entries_in;
   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   fresh_ff, fresh_in;
   logic                   full_ff, full_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [READING_W-1:0] thr_ff;

   // item payload and working statistics
   logic [KEY_W-1:0]            key_ff, key_in;
   logic signed [READING_W-1:0] rdg_ff, rdg_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic signed [READING_W-1:0] min_ff, min_in;
   logic signed [READING_W-1:0] max_ff, max_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;

   // divider: dividend shifts out at the top while quotient bits shift in
   logic [SUM_W-1:0]  dvd_ff, dvd_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              neg_ff, neg_in;

   // output register
   logic                        alert_ff, alert_in;
   logic signed [READING_W-1:0] mean_ff, mean_in;
   logic signed [READING_W-1:0] omin_ff, omin_in;
   logic signed [READING_W-1:0] omax_ff, omax_in;
   logic [COUNT_OUT_W-1:0]      ocnt_ff, ocnt_in;
   logic                        ofull_ff, ofull_in;

   // memory ports
   logic               key_we;
   logic [IDX_W-1:0]   key_waddr, key_raddr;
   logic [KEY_W-1:0]   key_rdata;
   logic               stat_we;
   logic [IDX_W-1:0]   stat_raddr;
   logic [STAT_W-1:0]  stat_wdata, stat_rdata;

   // helpers
   logic signed [SUM_W-1:0]     old_sum;
   logic signed [READING_W-1:0] old_min, old_max;
   logic [CNT_W-1:0]            old_cnt;
   logic [CNT_W:0]              trial;
   logic                        trial_ge;
   logic [USED_W-1:0]           scan_next;
   logic [READING_W-1:0]        quot;
   logic [CNT_EXT_W-1:0]        cnt_ext;

   sst_ram #(.WIDTH(KEY_W), .DEPTH(SENSORS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_ff),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   sst_ram #(.WIDTH(STAT_W), .DEPTH(SENSORS)) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_we),
      .wr_addr (slot_ff),
      .wr_data (stat_wdata),
      .rd_addr (stat_raddr),
      .rd_data (stat_rdata)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alert         = alert_ff;
   assign rsp_mean          = mean_ff;
   assign rsp_minimum       = omin_ff;
   assign rsp_maximum       = omax_ff;
   assign rsp_reading_count = ocnt_ff;
   assign rsp_table_full    = ofull_ff;

   // old statistics; a freshly allocated entry starts empty
   assign old_sum = fresh_ff ? '0 : $signed(stat_rdata[STAT_W-1 -: SUM_W]);
   assign old_min = fresh_ff ? '0 : $signed(stat_rdata[CNT_W+2*READING_W-1 -: READING_W]);
   assign old_max = fresh_ff ? '0 : $signed(stat_rdata[CNT_W+READING_W-1 -: READING_W]);
   assign old_cnt = fresh_ff ? '0 : stat_rdata[CNT_W-1:0];

   assign scan_next = USED_W'(scan_ff) + USED_W'(1);
   assign trial     = {rem_ff, dvd_ff[SUM_W-1]};
   assign trial_ge  = (trial >= {1'b0, cnt_ff});
   assign quot      = dvd_ff[READING_W-1:0];
   assign cnt_ext   = CNT_EXT_W'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= ALERT_THRESHOLD_RESET;
      end else begin
         state_ff     <= state_in;
         entries_ff   <= entries_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_alert_threshold;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      slot_ff  <= slot_in;
      fresh_ff <= fresh_in;
      full_ff  <= full_in;
      step_ff  <= step_in;
      key_ff   <= key_in;
      rdg_ff   <= rdg_in;
      sum_ff   <= sum_in;
      min_ff   <= min_in;
      max_ff   <= max_in;
      cnt_ff   <= cnt_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      alert_ff <= alert_in;
      mean_ff  <= mean_in;
      omin_ff  <= omin_in;
      omax_ff  <= omax_in;
      ocnt_ff  <= ocnt_in;
      ofull_ff <= ofull_in;
   end

   always_comb begin
      state_in     = state_ff;
      entries_in   = entries_ff;
      scan_in      = scan_ff;
      slot_in      = slot_ff;
      fresh_in     = fresh_ff;
      full_in      = full_ff;
      step_in      = step_ff;
      key_in       = key_ff;
      rdg_in       = rdg_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      cnt_in       = cnt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      alert_in     = alert_ff;
      mean_in      = mean_ff;
      omin_in      = omin_ff;
      omax_in      = omax_ff;
      ocnt_in      = ocnt_ff;
      ofull_in     = ofull_ff;

      key_we     = 1'b0;
      key_waddr  = entries_ff[IDX_W-1:0];
      key_raddr  = '0;
      stat_we    = 1'b0;
      stat_raddr = scan_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in  = req_sensor_key;
               rdg_in  = req_reading;
               full_in = 1'b0;
               scan_in = '0;
               // key of entry 0 is read now, compared next cycle
               state_in = (entries_ff == '0) ? ST_MISS : ST_SCAN;
            end
         end

         ST_SCAN: begin
            key_raddr = IDX_W'(scan_next);
            if (key_rdata == key_ff) begin
               slot_in  = scan_ff;
               fresh_in = 1'b0;
               state_in = ST_STAT;
            end else if (scan_next == entries_ff) begin
               state_in = ST_MISS;
            end else begin
               scan_in = IDX_W'(scan_next);
            end
         end

         ST_MISS: begin
            if (entries_ff == USED_W'(SENSORS)) begin
               full_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               key_we     = 1'b1;
               slot_in    = entries_ff[IDX_W-1:0];
               fresh_in   = 1'b1;
               entries_in = entries_ff + USED_W'(1);
               state_in   = ST_STAT;
            end
         end

         ST_STAT: begin
            sum_in = old_sum;
            min_in = old_min;
            max_in = old_max;
            cnt_in = old_cnt;
            if (old_cnt < CNT_W'(READING_CAP)) begin
               sum_in = old_sum + SUM_W'(rdg_ff);
               cnt_in = old_cnt + CNT_W'(1);
               if (old_cnt == '0) begin
                  min_in = rdg_ff;
                  max_in = rdg_ff;
               end else begin
                  if (rdg_ff < old_min) min_in = rdg_ff;
                  if (rdg_ff > old_max) max_in = rdg_ff;
               end
               stat_we = 1'b1;
            end
            neg_in   = sum_in[SUM_W-1];
            dvd_in   = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
            rem_in   = '0;
            step_in  = STEP_W'(SUM_W - 1);
            state_in = ST_DIV;
         end

         ST_DIV: begin
            rem_in  = trial_ge ? CNT_W'(trial - {1'b0, cnt_ff}) : trial[CNT_W-1:0];
            dvd_in  = {dvd_ff[SUM_W-2:0], trial_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               ofull_in     = full_ff;
               if (full_ff) begin
                  alert_in = 1'b0;
                  mean_in  = '0;
                  omin_in  = '0;
                  omax_in  = '0;
                  ocnt_in  = '0;
               end else begin
                  alert_in = (rdg_ff > thr_ff);
                  mean_in  = neg_ff ? $signed(~quot + 16'd1) : $signed(quot);
                  omin_in  = min_ff;
                  omax_in  = max_ff;
                  ocnt_in  = cnt_ext[COUNT_OUT_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // write-back carries the updated statistics
      stat_wdata = {sum_in, min_in, max_in, cnt_in};
   end

`ifndef SYNTH
   a_entries_bound: assert property (@(posedge clock) disable iff (reset)
      entries_ff <= USED_W'(SENSORS))
      else $error("entry count beyond table size");

   a_entries_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_MISS |=> $stable(entries_ff))
      else $error("entry count moved outside allocation");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff != '0)
      else $error("divide by zero count");

   a_full_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ofull_ff |-> !alert_ff && mean_ff == '0 && omin_ff == '0
                                   && omax_ff == '0 && ocnt_ff == '0)
      else $error("table_full beat carries nonzero fields");
`endif

endmodule
`default_nettype wire

[tb/tb_sensor_stats_table_core.sv]
// Self-checking testbench for sensor_stats_table_core: directed and random reading traffic.
module tb_sensor_stats_table_core
   import sst_pkg::*;
();

   localparam int TABLE_DEPTH     = 32;
   localparam int READING_CAP     = 256;
   // The hold-off below is the longest quiet spell.
   localparam int ITEM_LATENCY    = 100;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STUCK_LIMIT     = 3000;

   localparam logic [KEY_W-1:0] KEY_LO  = '0;
   localparam logic [KEY_W-1:0] KEY_HI  = {KEY_W{1'b1}};
   localparam logic [KEY_W-1:0] KEY_MID = 48'hC0A8_0102_1F90;

   typedef struct packed {
      logic                        alert;
      logic signed [READING_W-1:0] mean;
      logic signed [READING_W-1:0] minimum;
      logic signed [READING_W-1:0] maximum;
      logic [COUNT_OUT_W-1:0]      reading_count;
      logic                        table_full;
   } sensor_stats_type;

   logic                        clock;
   logic                        reset;
   logic                        csr_valid;
   logic                        csr_ready;
   logic signed [READING_W-1:0] csr_alert_threshold;
   logic                        req_valid;
   logic                        req_ready;
   logic [KEY_W-1:0]            req_sensor_key;
   logic signed [READING_W-1:0] req_reading;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic                        rsp_alert;
   logic signed [READING_W-1:0] rsp_mean;
   logic signed [READING_W-1:0] rsp_minimum;
   logic signed [READING_W-1:0] rsp_maximum;
   logic [COUNT_OUT_W-1:0]      rsp_reading_count;
   logic                        rsp_table_full;

   // Shadow copy of the sensor table and the threshold register.
   logic [KEY_W-1:0]            known_key    [TABLE_DEPTH];
   longint                      sensor_sum   [TABLE_DEPTH];
   logic signed [READING_W-1:0] sensor_min   [TABLE_DEPTH];
   logic signed [READING_W-1:0] sensor_max   [TABLE_DEPTH];
   int                          sensor_count [TABLE_DEPTH];
   int                          sensors_seen;
   logic signed [READING_W-1:0] threshold;

   sensor_stats_type expected_stats[$];
   int               failures = 0;
   bit               send_gaps_on;
   bit               rsp_stalls_on;
   int               hold_off_request;

   sensor_stats_table_core #(
      .SENSORS    (TABLE_DEPTH),
      .READING_CAP(READING_CAP)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_alert_threshold(csr_alert_threshold),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sensor_key     (req_sensor_key),
      .req_reading        (req_reading),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_alert          (rsp_alert),
      .rsp_mean           (rsp_mean),
      .rsp_minimum        (rsp_minimum),
      .rsp_maximum        (rsp_maximum),
      .rsp_reading_count  (rsp_reading_count),
      .rsp_table_full     (rsp_table_full)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 80);
   endfunction

   // Look the key up, allocate on first sight, fold the reading in below the cap,
   // and form the stats the rsp beat must carry.
   function automatic sensor_stats_type update_sensor(input logic [KEY_W-1:0] key,
                                                      input logic signed [READING_W-1:0] rd);
      sensor_stats_type res;
      int               slot;
      longint           quotient;
      res  = '0;
      slot = -1;
      for (int i = 0; i < sensors_seen; i++) begin
         if (slot < 0 && known_key[i] == key) slot = i;
      end
      if (slot < 0) begin
         if (sensors_seen >= TABLE_DEPTH) begin
            // no free entry: flag only, every other field zero
            res.table_full = 1'b1;
            return res;
         end
         slot               = sensors_seen;
         sensors_seen       = sensors_seen + 1;
         known_key[slot]    = key;
         sensor_sum[slot]   = 0;
         sensor_count[slot] = 0;
      end
      if (sensor_count[slot] < READING_CAP) begin
         if (sensor_count[slot] == 0) begin
            sensor_min[slot] = rd;
            sensor_max[slot] = rd;
         end else begin
            if (rd < sensor_min[slot]) sensor_min[slot] = rd;
            if (rd > sensor_max[slot]) sensor_max[slot] = rd;
         end
         sensor_sum[slot]   = sensor_sum[slot] + rd;
         sensor_count[slot] = sensor_count[slot] + 1;
      end
      // longint division truncates toward zero
      quotient          = sensor_sum[slot] / longint'(sensor_count[slot]);
      res.alert         = (rd > threshold);
      res.mean          = quotient[READING_W-1:0];
      res.minimum       = sensor_min[slot];
      res.maximum       = sensor_max[slot];
      res.reading_count = sensor_count[slot][COUNT_OUT_W-1:0];
      return res;
   endfunction

   function automatic logic signed [READING_W-1:0] pick_reading();
      int sel;
      int t;
      sel = $urandom_range(0, 99);
      if (sel < 45) return READING_W'($urandom);
      if (sel < 65) begin
         // right around the alert edge
         t = threshold + $urandom_range(0, 4) - 2;
         return READING_W'(t);
      end
      if (sel < 80) begin
         case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      // plausible room and outdoor temperatures
      t = $urandom_range(0, 1600) - 400;
      return READING_W'(t);
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if (sensors_seen > 0 && $urandom_range(0, 99) < 60)
         return known_key[$urandom_range(0, sensors_seen - 1)];
      return {$urandom, 16'($urandom)};
   endfunction

   // Called at a falling edge; returns at a falling edge with req_valid still high,
   // so back-to-back beats never lower and raise valid in one step.
   task automatic send_reading(input logic [KEY_W-1:0] key,
                               input logic signed [READING_W-1:0] rd);
      int gap;
      gap = send_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_sensor_key <= key;
      req_reading    <= rd;
      do @(posedge clock); while (!req_ready);
      expected_stats.push_back(update_sensor(key, rd));
      @(negedge clock);
   endtask

   // Stop offering and wait for every outstanding rsp beat.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_stats.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Only called with the block idle, and never twice in a row.
   task automatic write_threshold(input logic signed [READING_W-1:0] value);
      csr_valid           <= 1'b1;
      csr_alert_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      threshold = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Extreme keys and readings, mean truncation on both signs, alert at and just
   // above the reset threshold.
   task automatic test_extremes();
      send_reading(KEY_LO, 16'sh8000);
      send_reading(KEY_LO, 16'shFFFF);
      send_reading(KEY_HI, 16'sh7FFF);
      send_reading(KEY_HI, 16'sh7FFF);
      send_reading(KEY_HI, 16'sh8000);
      send_reading(KEY_MID, 16'sd560);
      send_reading(KEY_MID, 16'sd561);
      send_reading(KEY_MID, 16'sd559);
      send_reading(KEY_MID, 16'sd0);
      send_reading(KEY_LO, 16'sd3);
      drain_results();
   endtask

   // Threshold at both extremes, zero and a random value, then back to reset value.
   task automatic test_threshold_register();
      write_threshold(16'sh8000);
      send_reading(KEY_MID, 16'sh8000);
      send_reading(KEY_MID, 16'sh8001);
      drain_results();
      write_threshold(16'sh7FFF);
      send_reading(KEY_HI, 16'sh7FFF);
      send_reading(KEY_HI, 16'sh7FFE);
      drain_results();
      write_threshold(16'sd0);
      send_reading(KEY_MID, 16'sd0);
      send_reading(KEY_MID, 16'sd1);
      send_reading(KEY_MID, 16'shFFFF);
      drain_results();
      write_threshold(READING_W'($urandom));
      send_reading(KEY_MID, pick_reading());
      send_reading(KEY_MID, pick_reading());
      drain_results();
      write_threshold(ALERT_THRESHOLD_RESET);
   endtask

   // Push one sensor past the reading cap; first half runs with no idling at all.
   task automatic test_reading_cap();
      send_gaps_on  = 1'b0;
      rsp_stalls_on = 1'b0;
      for (int n = 0; n < 260; n++) begin
         if (n == 130) begin
            send_gaps_on  = 1'b1;
            rsp_stalls_on = 1'b1;
         end
         send_reading(KEY_LO, pick_reading());
      end
      // stats are frozen now, alert still follows the beat
      send_reading(KEY_LO, 16'sh7FFF);
      send_reading(KEY_LO, 16'sh8000);
      drain_results();
   endtask

   // Mixed known and fresh keys: fills the table, then keeps hitting table full.
   task automatic test_random_traffic();
      for (int half = 0; half < 2; half++) begin
         write_threshold(READING_W'($urandom));
         repeat (125) send_reading(pick_key(), pick_reading());
         drain_results();
      end
   endtask

   // Receiver goes quiet for a long stretch while req beats keep coming, so the
   // output register fills and req_ready drops; then wait for everything to return.
   task automatic test_backpressure();
      send_gaps_on     = 1'b0;
      hold_off_request = HOLD_OFF_CYCLES;
      repeat (12) send_reading(pick_key(), pick_reading());
      drain_results();
      send_gaps_on = 1'b1;
   endtask

   // Response side: random stalls, plus the long hold-off on request.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request > 0) begin
            stall_left       = hold_off_request;
            hold_off_request = 0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
            rsp_ready  <= 1'b0;
            stall_left = pick_gap();
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every rsp beat is matched against the oldest expectation.
   always @(posedge clock) begin
      sensor_stats_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_stats.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected rsp beat: mean=%0d count=%0d full=%0b",
                        rsp_mean, rsp_reading_count, rsp_table_full);
         end else begin
            want = expected_stats.pop_front();
            if (want.alert !== rsp_alert || want.mean !== rsp_mean ||
                want.minimum !== rsp_minimum || want.maximum !== rsp_maximum ||
                want.reading_count !== rsp_reading_count ||
                want.table_full !== rsp_table_full) begin
               failures++;
               if (failures <= 10) begin
                  $display("mismatch: expected alert=%0b mean=%0d min=%0d max=%0d count=%0d full=%0b",
                           want.alert, want.mean, want.minimum, want.maximum,
                           want.reading_count, want.table_full);
                  $display("          actual   alert=%0b mean=%0d min=%0d max=%0d count=%0d full=%0b",
                           rsp_alert, rsp_mean, rsp_minimum, rsp_maximum,
                           rsp_reading_count, rsp_table_full);
               end
            end
         end
      end
   end

   // Ends the run when no beat moves on any channel for too long.
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_sensor_key      = '0;
      req_reading         = '0;
      csr_valid           = 1'b0;
      csr_alert_threshold = '0;
      send_gaps_on        = 1'b1;
      rsp_stalls_on       = 1'b1;
      hold_off_request    = 0;
      sensors_seen        = 0;
      threshold           = ALERT_THRESHOLD_RESET;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_threshold_register();
      test_reading_cap();
      test_random_traffic();
      test_backpressure();

      // every test drains; give stray beats time to show up
      repeat (ITEM_LATENCY) @(posedge clock);
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
